@@ rtl/core/pst_pkg.sv @@
package pst_pkg;

  // table geometry and field widths
  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned PID_W  = 16;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned PRIO_W = 2;

  // process state and priority codes
  localparam logic [ST_W-1:0]   PS_TERMINATED = 3'd0;
  localparam logic [ST_W-1:0]   PS_READY      = 3'd1;
  localparam logic [PRIO_W-1:0] PRIO_NORMAL   = 2'd1;

  // request codes
  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE  = 3'd0,
    FN_TERM    = 3'd1,
    FN_SET     = 3'd2,
    FN_GET     = 3'd3,
    FN_FIND    = 3'd4,
    FN_COUNT   = 3'd5,
    FN_ITER    = 3'd6
  } pst_func_e;

  // sequencer states
  typedef enum logic {
    SQ_IDLE,
    SQ_SCAN
  } pst_seq_e;

  // request transfer
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PID_W-1:0]  pid_in;
    logic [ST_W-1:0]   new_state;
    logic [PRIO_W-1:0] prio_in;
    logic              from_start;
    logic [SLOT_W-1:0] prev_slot;
  } pst_req_t;

  // result transfer
  typedef struct packed {
    logic              ok;
    logic [PID_W-1:0]  pid_out;
    logic [SLOT_W-1:0] slot_out;
    logic [ST_W-1:0]   state_out;
    logic [PRIO_W-1:0] prio_out;
    logic [CNT_W-1:0]  count_out;
  } pst_res_t;

  // one slot of the table
  typedef struct packed {
    logic              active;
    logic [PID_W-1:0]  pid;
    logic [ST_W-1:0]   state;
    logic [PRIO_W-1:0] prio;
  } pst_entry_t;

  // slot write from the sequencer
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    pst_entry_t        entry;
  } pst_wr_t;

endpackage

@@ rtl/core/pst_table.sv @@
module pst_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pst_pkg::pst_wr_t           wr_i,
  input  logic [pst_pkg::SLOT_W-1:0] rd_idx_i,
  output pst_pkg::pst_entry_t        rd_o
);
  import pst_pkg::*;

  pst_entry_t slot_q [SLOTS];

  // slot storage, cleared to free slots of normal priority
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_q[i].active <= 1'b0;
        slot_q[i].pid    <= '0;
        slot_q[i].state  <= PS_TERMINATED;
        slot_q[i].prio   <= PRIO_NORMAL;
      end
    end else if (wr_i.en) begin
      slot_q[wr_i.idx] <= wr_i.entry;
    end
  end

  // single read port at the scan index
  assign rd_o = slot_q[rd_idx_i];

endmodule

@@ rtl/core/process_slot_table.sv @@
// done_o rises in the cycle after the transfer for count, undefined codes and
// immediate failures; scans check one slot a cycle from their start slot, done_o
// the cycle after the hit or the last slot.
// busy holds during a scan and drops in the cycle done_o rises, when a new transfer
// can be taken; no request is taken while a scan runs; immediate ones go back to back.
// Reset clears the table and the live count and sets the pid counter to 1.
module process_slot_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  pst_pkg::pst_req_t req_i,
  output logic              busy,
  output logic              done_o,
  output pst_pkg::pst_res_t res_o
);
  import pst_pkg::*;

  localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_IDX  = SLOT_W'(SLOTS - 1);

  pst_seq_e          seq_q, seq_d;
  pst_req_t          req_q, req_d;
  pst_res_t          res_q, res_d;
  logic              done_q, done_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PID_W-1:0]  ctr_q, ctr_d;
  logic [PID_W-1:0]  ctr_inc;
  pst_wr_t           wr;
  pst_entry_t        rd;
  logic              hit;

  pst_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_idx_i (idx_q),
    .rd_o     (rd)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= SQ_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
      ctr_q  <= PID_W'(1);
    end else begin
      seq_q  <= seq_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      ctr_q  <= ctr_d;
    end
  end

  // request, scan index and result payload
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  // pid counter step, skipping zero on wrap
  assign ctr_inc = (ctr_q + PID_W'(1) == '0) ? PID_W'(1) : ctr_q + PID_W'(1);

  // shared slot compare for the request in flight
  always_comb begin
    case (req_q.func)
      FN_CREATE: hit = !rd.active;
      FN_ITER:   hit = rd.active;
      default:   hit = rd.active && (rd.pid == req_q.pid_in);
    endcase
  end

  // sequencer
  always_comb begin
    seq_d  = seq_q;
    req_d  = req_q;
    idx_d  = idx_q;
    res_d  = res_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    ctr_d  = ctr_q;
    wr     = '0;

    case (seq_q)
      SQ_IDLE: begin
        if (start) begin
          req_d           = req_i;
          idx_d           = '0;
          res_d           = '0;
          res_d.count_out = cnt_q;
          case (req_i.func)
            FN_CREATE: begin
              if (cnt_q >= SLOTS_CNT) begin
                done_d = 1'b1;
              end else begin
                seq_d = SQ_SCAN;
              end
            end
            FN_TERM, FN_SET, FN_GET, FN_FIND: begin
              if (req_i.pid_in == '0) begin
                done_d = 1'b1;
              end else begin
                seq_d = SQ_SCAN;
              end
            end
            FN_COUNT: begin
              res_d.ok = 1'b1;
              done_d   = 1'b1;
            end
            FN_ITER: begin
              if (req_i.from_start || ({1'b0, req_i.prev_slot} >= (SLOT_W + 1)'(SLOTS))) begin
                seq_d = SQ_SCAN;
              end else if (req_i.prev_slot == LAST_IDX) begin
                done_d = 1'b1;
              end else begin
                idx_d = req_i.prev_slot + SLOT_W'(1);
                seq_d = SQ_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      SQ_SCAN: begin
        if (hit) begin
          res_d.ok        = 1'b1;
          res_d.pid_out   = rd.pid;
          res_d.slot_out  = idx_q;
          res_d.state_out = rd.state;
          res_d.prio_out  = rd.prio;
          res_d.count_out = cnt_q;
          wr.idx          = idx_q;
          wr.entry        = rd;
          case (req_q.func)
            FN_CREATE: begin
              wr.en           = 1'b1;
              wr.entry.active = 1'b1;
              wr.entry.pid    = ctr_q;
              wr.entry.state  = PS_READY;
              wr.entry.prio   = req_q.prio_in;
              res_d.pid_out   = ctr_q;
              res_d.state_out = PS_READY;
              res_d.prio_out  = req_q.prio_in;
              cnt_d           = cnt_q + CNT_W'(1);
              res_d.count_out = cnt_q + CNT_W'(1);
              ctr_d           = ctr_inc;
            end
            FN_TERM: begin
              wr.en           = 1'b1;
              wr.entry.active = 1'b0;
              wr.entry.state  = PS_TERMINATED;
              res_d.state_out = PS_TERMINATED;
              if (cnt_q != '0) begin
                cnt_d           = cnt_q - CNT_W'(1);
                res_d.count_out = cnt_q - CNT_W'(1);
              end
            end
            FN_SET: begin
              wr.en           = 1'b1;
              wr.entry.state  = req_q.new_state;
              res_d.state_out = req_q.new_state;
            end
            default: begin
            end
          endcase
          done_d = 1'b1;
          seq_d  = SQ_IDLE;
        end else if (idx_q == LAST_IDX) begin
          // no slot found: failure result
          res_d           = '0;
          res_d.count_out = cnt_q;
          done_d          = 1'b1;
          seq_d           = SQ_IDLE;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end

      default: begin
        seq_d = SQ_IDLE;
      end
    endcase
  end

  assign busy   = (seq_q != SQ_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // a scan never ends without a result strobe
  a_scan_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (busy || done_o))
    else $error("scan ended without a result");

  // live count stays within the table
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SLOTS_CNT)
    else $error("live count above table size");

  // pid counter never hands out zero
  a_ctr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctr_q != '0)
    else $error("pid counter reached zero");

  // count request answers in the next cycle with ok set
  a_count_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.func == FN_COUNT)) |=> (done_o && res_o.ok))
    else $error("count request not answered");

endmodule

@@ dv/slot_table_checker.sv @@
module slot_table_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  pst_pkg::pst_req_t req_i,
  input  logic              done_i,
  input  pst_pkg::pst_res_t res_i,
  output int unsigned       fail_cnt_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  // shadow copy of the process table
  logic              tbl_active [SLOTS];
  logic [PID_W-1:0]  tbl_pid    [SLOTS];
  logic [ST_W-1:0]   tbl_state  [SLOTS];
  logic [PRIO_W-1:0] tbl_prio   [SLOTS];
  logic [PID_W-1:0]  pid_ctr;
  logic [CNT_W-1:0]  live_slots;

  // replies owed by the block, oldest first
  pst_res_t          replies_q [$];
  pst_res_t          want;
  logic              bad;

  // what a request reports for one slot, live count filled in later
  function automatic pst_res_t slot_view(input int idx);
    pst_res_t v;
    v           = '0;
    v.ok        = 1'b1;
    v.pid_out   = tbl_pid[idx];
    v.slot_out  = SLOT_W'(idx);
    v.state_out = tbl_state[idx];
    v.prio_out  = tbl_prio[idx];
    return v;
  endfunction

  // apply one request to the shadow table and work out its reply
  function automatic pst_res_t run_table_request(input pst_req_t r);
    pst_res_t res;
    int       match;
    int       free_idx;
    int       first;
    res      = '0;
    match    = -1;
    free_idx = -1;
    // lowest active slot holding the pid, pid 0 never matches
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (r.pid_in != '0 && tbl_active[i] && tbl_pid[i] == r.pid_in) match = i;
      if (!tbl_active[i]) free_idx = i;
    end
    case (r.func)
      FN_CREATE: begin
        if (live_slots < SLOTS && free_idx >= 0) begin
          tbl_pid[free_idx]    = pid_ctr;
          tbl_state[free_idx]  = PS_READY;
          tbl_prio[free_idx]   = r.prio_in;
          tbl_active[free_idx] = 1'b1;
          live_slots           = live_slots + 1'b1;
          // counter skips zero on wrap
          pid_ctr = pid_ctr + 1'b1;
          if (pid_ctr == '0) pid_ctr = PID_W'(1);
          res = slot_view(free_idx);
        end
      end
      FN_TERM: begin
        if (match >= 0) begin
          tbl_state[match]  = PS_TERMINATED;
          tbl_active[match] = 1'b0;
          if (live_slots != '0) live_slots = live_slots - 1'b1;
          res = slot_view(match);
        end
      end
      FN_SET: begin
        if (match >= 0) begin
          tbl_state[match] = r.new_state;
          res = slot_view(match);
        end
      end
      FN_GET, FN_FIND: begin
        if (match >= 0) res = slot_view(match);
      end
      FN_COUNT: res.ok = 1'b1;
      FN_ITER: begin
        // an out-of-range previous slot restarts the walk at slot 0
        first = (r.from_start || r.prev_slot >= SLOTS) ? 0 : int'(r.prev_slot) + 1;
        for (int i = first; i < SLOTS; i++) begin
          if (tbl_active[i]) begin
            res = slot_view(i);
            break;
          end
        end
      end
      default: ;
    endcase
    res.count_out = live_slots;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_active[i] = 1'b0;
        tbl_pid[i]    = '0;
        tbl_state[i]  = PS_TERMINATED;
        tbl_prio[i]   = PRIO_NORMAL;
      end
      pid_ctr    = PID_W'(1);
      live_slots = '0;
      replies_q.delete();
      fail_cnt_o = 0;
    end else begin
      // result transfer, checked against the oldest owed reply
      if (done_i === 1'b1) begin
        if (replies_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= MAX_REPORTS)
            $display("[%0t] result with nothing outstanding: ok=%0b pid=%0d slot=%0d",
                     $realtime, res_i.ok, res_i.pid_out, res_i.slot_out);
        end else begin
          want = replies_q.pop_front();
          bad  = (res_i.ok !== want.ok) || (res_i.pid_out !== want.pid_out) ||
                 (res_i.slot_out !== want.slot_out) ||
                 (res_i.state_out !== want.state_out) ||
                 (res_i.prio_out !== want.prio_out) ||
                 (res_i.count_out !== want.count_out);
          if (bad) begin
            fail_cnt_o++;
            if (fail_cnt_o <= MAX_REPORTS)
              $display({"[%0t] mismatch: expected ok=%0b pid=%0d slot=%0d state=%0d",
                        " prio=%0d count=%0d, got ok=%0b pid=%0d slot=%0d state=%0d",
                        " prio=%0d count=%0d"},
                       $realtime, want.ok, want.pid_out, want.slot_out,
                       want.state_out, want.prio_out, want.count_out,
                       res_i.ok, res_i.pid_out, res_i.slot_out,
                       res_i.state_out, res_i.prio_out, res_i.count_out);
          end
        end
      end
      // request transfer
      if (start_i === 1'b1 && busy_i === 1'b0) replies_q.push_back(run_table_request(req_i));
    end
    pending_o = replies_q.size();
  end

endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNDEF     = 3'd7;
  localparam int unsigned       RANDOM_ITEMS = 850;
  localparam int unsigned       WRAP_PAIRS   = 64;
  localparam int unsigned       LIMIT_CYCLES = 500_000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  pst_req_t    req;
  logic        busy;
  logic        done_o;
  pst_res_t    res;
  int unsigned fail_cnt;
  int unsigned pending;

  int unsigned      max_gap;
  logic [PID_W-1:0] seen_pids [$];
  logic [PID_W-1:0] wrap_pid;
  int unsigned      random_items;
  int unsigned      kind;
  int unsigned      burst;
  int unsigned      create_pct;
  logic [FUNC_W-1:0] f;

  process_slot_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res)
  );

  slot_table_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req),
    .done_i     (done_o),
    .res_i      (res),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  // remember recently reported pids so lookups mostly hit
  always @(posedge clk_i) begin
    if (done_o === 1'b1 && res.ok === 1'b1 && res.pid_out != '0) begin
      seen_pids.push_back(res.pid_out);
      if (seen_pids.size() > 24) void'(seen_pids.pop_front());
    end
  end

  function automatic pst_req_t mk_req(input logic [FUNC_W-1:0] fn,
                                      input logic [PID_W-1:0]  pid,
                                      input logic [ST_W-1:0]   st,
                                      input logic [PRIO_W-1:0] prio,
                                      input logic              fs,
                                      input logic [SLOT_W-1:0] prev);
    pst_req_t r;
    r.func       = fn;
    r.pid_in     = pid;
    r.new_state  = st;
    r.prio_in    = prio;
    r.from_start = fs;
    r.prev_slot  = prev;
    return r;
  endfunction

  function automatic logic [PID_W-1:0] pick_pid();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80 && seen_pids.size() != 0)
      return seen_pids[$urandom_range(0, seen_pids.size() - 1)];
    if (roll < 85) return '0;
    if (roll < 90) return '1;
    return PID_W'($urandom);
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(input int unsigned pct);
    int unsigned roll;
    if ($urandom_range(0, 99) < pct) return FN_CREATE;
    roll = $urandom_range(0, 99);
    if (roll < 28) return FN_TERM;
    if (roll < 48) return FN_SET;
    if (roll < 60) return FN_GET;
    if (roll < 72) return FN_FIND;
    if (roll < 78) return FN_COUNT;
    if (roll < 95) return FN_ITER;
    return FN_UNDEF;
  endfunction

  // one request transfer, optionally after an idle gap; returns on a falling edge
  task automatic issue(input pst_req_t r);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    req     = '0;
    max_gap = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, then a few slots exercised
    max_gap = 3;
    issue(mk_req(FN_COUNT, '0, '0, '0, 1'b0, '0));
    issue(mk_req(FN_GET,   '0, '0, '0, 1'b0, '0));
    issue(mk_req(FN_FIND,  16'd1, '0, '0, 1'b0, '0));
    issue(mk_req(FN_ITER,  '0, '0, '0, 1'b1, '0));
    issue(mk_req(FN_TERM,  16'd1, '0, '0, 1'b0, '0));
    issue(mk_req(FN_CREATE, '0, '0, 2'd0, 1'b0, '0));
    issue(mk_req(FN_CREATE, '1, '1, 2'd3, 1'b1, '1));
    issue(mk_req(FN_CREATE, '0, '0, 2'd2, 1'b0, '0));
    issue(mk_req(FN_SET,   16'd2, 3'd7, '0, 1'b0, '0));
    issue(mk_req(FN_SET,   16'd3, 3'd0, '1, 1'b1, '1));
    issue(mk_req(FN_GET,   16'd2, '0, '0, 1'b0, '0));
    issue(mk_req(FN_FIND,  16'd3, '0, '0, 1'b0, '0));
    issue(mk_req(FN_FIND,  '1, '0, '0, 1'b0, '0));
    issue(mk_req(FN_ITER,  '0, '0, '0, 1'b0, 4'd0));
    issue(mk_req(FN_ITER,  '0, '0, '0, 1'b0, 4'd14));
    // iterate past the last slot
    issue(mk_req(FN_ITER,  '0, '0, '0, 1'b0, 4'd15));
    issue(mk_req(FN_TERM,  16'd2, '0, '0, 1'b0, '0));
    issue(mk_req(FN_TERM,  16'd2, '0, '0, 1'b0, '0));
    issue(mk_req(FN_UNDEF, '1, '1, '1, 1'b1, '1));
    issue(mk_req(FN_COUNT, '1, '1, '1, 1'b1, '1));

    // back-to-back churn of one slot while pids 1 and 3 stay live
    max_gap  = 0;
    wrap_pid = 16'd4;
    repeat (WRAP_PAIRS) begin
      issue(mk_req(FN_CREATE, '0, '0, PRIO_W'($urandom), 1'b0, '0));
      issue(mk_req(FN_TERM, wrap_pid, '0, '0, 1'b0, '0));
      wrap_pid = wrap_pid + 1'b1;
      if (wrap_pid == '0) wrap_pid = 16'd1;
    end
    // lookups of the long-lived pids
    issue(mk_req(FN_GET,  16'd1, '0, '0, 1'b0, '0));
    issue(mk_req(FN_FIND, 16'd3, '0, '0, 1'b0, '0));
    issue(mk_req(FN_ITER, '0, '0, '0, 1'b1, '0));

    // random bursts: fill, drain and mixed traffic at varying idle levels
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: max_gap = 0;
        1: max_gap = 4;
        default: max_gap = 13;
      endcase
      kind       = $urandom_range(0, 4);
      burst      = (kind == 0) ? SLOTS + 2 : (kind == 1) ? 12 : 40;
      create_pct = 15 + 20 * $urandom_range(0, 2);
      repeat (burst) begin
        if (kind == 0) f = FN_CREATE;
        else if (kind == 1) f = FN_TERM;
        else f = pick_func(create_pct);
        issue(mk_req(f, pick_pid(), ST_W'($urandom), PRIO_W'($urandom),
                     1'($urandom), SLOT_W'($urandom)));
        random_items++;
      end
    end
    start <= 1'b0;

    // drain outstanding replies, then allow for any stray result
    while (pending != 0) @(negedge clk_i);
    repeat (SLOTS + 4) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pst_pkg.sv
rtl/core/pst_table.sv
rtl/core/process_slot_table.sv
dv/slot_table_checker.sv
dv/testbench.sv
